[hdl/sle_pkg.sv]
// Shared constants, codes and the result record of the sequential list engine.
// No dependencies; every other file of the block refers to it by scoped names.
package sle_pkg;

	localparam int DEPTH_DEF      = 32;
	localparam int ELEM_WIDTH_DEF = 32;

	localparam int MODE_W   = 2;
	localparam int POS_IN_W = 6;
	localparam int DATA_W   = 32;
	localparam int STATUS_W = 2;
	localparam int POS_W    = 5;
	localparam int COUNT_W  = 6;

	localparam logic [MODE_W-1:0] MODE_INSERT   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_SEARCH   = 2'd1;
	localparam logic [MODE_W-1:0] MODE_DELETE   = 2'd2;
	localparam logic [MODE_W-1:0] MODE_TRAVERSE = 2'd3;

	localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] ST_BAD_POS  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
	localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd3;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [POS_W-1:0]    position;
		logic [DATA_W-1:0]   element;
		logic [COUNT_W-1:0]  count;
		logic                last;
	} result_t;

endpackage

[hdl/sle_mem.sv]
// Entry store of the list: one write port and one read port, read data registered.
// Depends on sle_pkg for default sizes only.
module sle_mem #(
	parameter int DEPTH      = sle_pkg::DEPTH_DEF,
	parameter int ELEM_WIDTH = sle_pkg::ELEM_WIDTH_DEF,
	localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                  clk,
	input  logic                  rd_en,
	input  logic [AW-1:0]         rd_addr,
	output logic [ELEM_WIDTH-1:0] rd_data,
	input  logic                  wr_en,
	input  logic [AW-1:0]         wr_addr,
	input  logic [ELEM_WIDTH-1:0] wr_data
);

	logic [ELEM_WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

[hdl/sle_out.sv]
// Output register of the result channel; parts the sequencer from the consumer.
// Depends on sle_pkg for the result record.
module sle_out (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	input  sle_pkg::result_t             push_res,
	output logic                         out_ready,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [sle_pkg::STATUS_W-1:0] status,
	output logic [sle_pkg::POS_W-1:0]    position_out,
	output logic [sle_pkg::DATA_W-1:0]   element_out,
	output logic [sle_pkg::COUNT_W-1:0]  count,
	output logic                         last
);

	logic             out_valid_q;
	sle_pkg::result_t res_q;

	assign out_ready = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_ready) begin
			out_valid_q <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ready && push) begin
			res_q <= push_res;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = res_q.status;
	assign position_out = res_q.position;
	assign element_out  = res_q.element;
	assign count        = res_q.count;
	assign last         = res_q.last;

endmodule

[hdl/sle_ctrl.sv]
// Operation sequencer: walks the entry store one address a cycle to shift, scan and emit;
// emitting waits on out_ready. Depends on sle_pkg; drives sle_mem and feeds sle_out.
module sle_ctrl #(
	parameter int DEPTH      = sle_pkg::DEPTH_DEF,
	parameter int ELEM_WIDTH = sle_pkg::ELEM_WIDTH_DEF,
	localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int CW        = $clog2(DEPTH + 1)
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [sle_pkg::MODE_W-1:0]   mode,
	input  logic [sle_pkg::POS_IN_W-1:0] position_in,
	input  logic [sle_pkg::DATA_W-1:0]   element_value,
	input  logic [sle_pkg::DATA_W-1:0]   search_key,
	input  logic [sle_pkg::DATA_W-1:0]   key_mask,
	input  logic                         out_ready,
	output logic                         push,
	output sle_pkg::result_t             push_res,
	output logic                         rd_en,
	output logic [AW-1:0]                rd_addr,
	input  logic [ELEM_WIDTH-1:0]        rd_data,
	output logic                         wr_en,
	output logic [AW-1:0]                wr_addr,
	output logic [ELEM_WIDTH-1:0]        wr_data
);

	localparam int XW = (CW > sle_pkg::POS_IN_W) ? CW : sle_pkg::POS_IN_W;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_INS  = 3'd1;
	localparam logic [2:0] S_SCAN = 3'd2;
	localparam logic [2:0] S_TOUT = 3'd3;
	localparam logic [2:0] S_EMIT = 3'd4;

	logic [2:0]                  state_q;
	logic [CW-1:0]               count_q;
	logic                        del_q;
	logic [CW-1:0]               pos_q;
	logic [ELEM_WIDTH-1:0]       val_q;
	logic [sle_pkg::DATA_W-1:0]  key_q;
	logic [CW-1:0]               rp_q;
	logic                        rv_s1;
	logic [AW-1:0]               ra_s1;
	logic                        found_q;
	logic [AW-1:0]               hit_idx_q;
	logic [ELEM_WIDTH-1:0]       hit_q;
	logic [CW-1:0]               tp_q;
	sle_pkg::result_t            res_q;

	logic [CW-1:0] rp_m1;
	logic [CW-1:0] rp_p1;
	logic [CW-1:0] tp_p1;
	logic [CW-1:0] cnt_inc;
	logic [CW-1:0] cnt_dec;
	logic          bad_pos;
	logic          match;
	logic          hit_now;
	logic          ins_rd;
	logic          ins_fin;
	logic          scan_done;
	logic          trav_last;

	function automatic sle_pkg::result_t make_res(
		logic [sle_pkg::STATUS_W-1:0] st,
		logic [sle_pkg::POS_W-1:0]    pos,
		logic [sle_pkg::DATA_W-1:0]   el,
		logic [sle_pkg::COUNT_W-1:0]  cnt,
		logic                         lst
	);
		sle_pkg::result_t r;
		r.status   = st;
		r.position = pos;
		r.element  = el;
		r.count    = cnt;
		r.last     = lst;
		return r;
	endfunction

	assign rp_m1     = rp_q - CW'(1);
	assign rp_p1     = rp_q + CW'(1);
	assign tp_p1     = tp_q + CW'(1);
	assign cnt_inc   = count_q + CW'(1);
	assign cnt_dec   = count_q - CW'(1);
	assign bad_pos   = (XW'(position_in) > XW'(count_q)) || (count_q == CW'(DEPTH));
	assign match     = ((rd_data ^ ELEM_WIDTH'(key_q)) & ELEM_WIDTH'(key_mask)) == '0;
	assign hit_now   = (state_q == S_SCAN) && rv_s1 && !found_q && match;
	assign ins_rd    = rp_q > pos_q;
	assign ins_fin   = !ins_rd && !rv_s1;
	assign scan_done = (rp_q == count_q) && !rv_s1;
	assign trav_last = tp_p1 == count_q;
	assign in_stall  = state_q != S_IDLE;

	always_comb begin
		rd_en    = 1'b0;
		rd_addr  = rp_q[AW-1:0];
		wr_en    = 1'b0;
		wr_addr  = ra_s1 + AW'(1);
		wr_data  = rd_data;
		push     = 1'b0;
		push_res = res_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid && mode == sle_pkg::MODE_TRAVERSE && count_q != '0) begin
					rd_en   = 1'b1;
					rd_addr = '0;
				end
			end
			S_INS: begin
				if (rv_s1) begin
					wr_en = 1'b1;
				end
				if (ins_rd) begin
					rd_en   = 1'b1;
					rd_addr = rp_m1[AW-1:0];
				end else if (!rv_s1) begin
					wr_en   = 1'b1;
					wr_addr = pos_q[AW-1:0];
					wr_data = val_q;
				end
			end
			S_SCAN: begin
				rd_en = (rp_q < count_q) && !(!del_q && hit_now);
				if (rv_s1 && found_q) begin
					wr_en   = 1'b1;
					wr_addr = ra_s1 - AW'(1);
				end
			end
			S_TOUT: begin
				push     = 1'b1;
				push_res = make_res(sle_pkg::ST_OK, sle_pkg::POS_W'(tp_q),
					sle_pkg::DATA_W'(rd_data), sle_pkg::COUNT_W'(count_q), trav_last);
				if (out_ready && !trav_last) begin
					rd_en   = 1'b1;
					rd_addr = tp_p1[AW-1:0];
				end
			end
			S_EMIT: begin
				push = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			rv_s1   <= 1'b0;
			found_q <= 1'b0;
		end else begin
			rv_s1 <= rd_en;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						unique case (mode)
							sle_pkg::MODE_INSERT: begin
								state_q <= bad_pos ? S_EMIT : S_INS;
							end
							sle_pkg::MODE_SEARCH, sle_pkg::MODE_DELETE: begin
								found_q <= 1'b0;
								state_q <= (count_q == '0) ? S_EMIT : S_SCAN;
							end
							default: begin
								state_q <= (count_q == '0) ? S_EMIT : S_TOUT;
							end
						endcase
					end
				end
				S_INS: begin
					if (ins_fin) begin
						count_q <= cnt_inc;
						state_q <= S_EMIT;
					end
				end
				S_SCAN: begin
					if (hit_now) begin
						found_q <= 1'b1;
						if (!del_q) begin
							state_q <= S_EMIT;
						end
					end else if (scan_done) begin
						if (found_q) begin
							count_q <= cnt_dec;
						end
						state_q <= S_EMIT;
					end
				end
				S_TOUT: begin
					if (out_ready && trav_last) begin
						state_q <= S_IDLE;
					end
				end
				S_EMIT: begin
					if (out_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		ra_s1 <= rd_addr;
		unique case (state_q)
			S_IDLE: begin
				pos_q <= CW'(position_in);
				val_q <= ELEM_WIDTH'(element_value);
				key_q <= search_key;
				del_q <= mode == sle_pkg::MODE_DELETE;
				rp_q  <= (mode == sle_pkg::MODE_INSERT) ? count_q : '0;
				tp_q  <= '0;
				if (mode == sle_pkg::MODE_INSERT) begin
					res_q <= make_res(sle_pkg::ST_BAD_POS, '0, '0,
						sle_pkg::COUNT_W'(count_q), 1'b1);
				end else begin
					res_q <= make_res(sle_pkg::ST_EMPTY, '0, '0,
						sle_pkg::COUNT_W'(count_q), 1'b1);
				end
			end
			S_INS: begin
				if (ins_rd) begin
					rp_q <= rp_m1;
				end
				if (ins_fin) begin
					res_q <= make_res(sle_pkg::ST_OK, sle_pkg::POS_W'(pos_q), '0,
						sle_pkg::COUNT_W'(cnt_inc), 1'b1);
				end
			end
			S_SCAN: begin
				if (rd_en) begin
					rp_q <= rp_p1;
				end
				if (hit_now) begin
					hit_idx_q <= ra_s1;
					hit_q     <= rd_data;
					res_q     <= make_res(sle_pkg::ST_OK, sle_pkg::POS_W'(ra_s1),
						sle_pkg::DATA_W'(rd_data), sle_pkg::COUNT_W'(count_q), 1'b1);
				end else if (scan_done) begin
					if (found_q) begin
						res_q <= make_res(sle_pkg::ST_OK, sle_pkg::POS_W'(hit_idx_q),
							sle_pkg::DATA_W'(hit_q), sle_pkg::COUNT_W'(cnt_dec), 1'b1);
					end else begin
						res_q <= make_res(sle_pkg::ST_NOT_FOUND, '0, '0,
							sle_pkg::COUNT_W'(count_q), 1'b1);
					end
				end
			end
			S_TOUT: begin
				if (out_ready && !trav_last) begin
					tp_q <= tp_p1;
				end
			end
			default: begin
			end
		endcase
	end

	a_no_same_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && rd_en) |-> (wr_addr != rd_addr))
		else $error("read and write hit the same entry in one cycle");

	a_scan_write_after_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN && wr_en) |-> (found_q && del_q))
		else $error("entry moved during a scan before a delete hit");

	a_count_change: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(count_q) |-> ($past(state_q) == S_INS || $past(state_q) == S_SCAN))
		else $error("entry count changed outside insert or delete");

	a_trav_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_TOUT && out_ready && !trav_last)
			|=> (state_q == S_TOUT && tp_q == $past(tp_p1)))
		else $error("traverse did not advance after a transfer");

endmodule

[hdl/sequential_list_engine_top.sv]
// Top level of the sequential list engine: mask register, sequencer, entry store, output stage.
// Depends on sle_pkg, sle_mem, sle_ctrl and sle_out.
//
// channel   direction  handshake            payload
// in        input      in_valid / in_stall   mode, position_in, element_value, search_key
// out       output     out_valid / out_stall status, position_out, element_out, count, last
// cfg       input      cfg_valid / cfg_ready cfg_data (key_mask)
//
// Insert moves entries from position to the end up by one, then writes the element;
// a bad position or a full list is rejected. Search scans from entry 0 to a hit, delete
// to the end, moving later entries down; an empty list is not scanned. Traverse gives one
// result a cycle unless out stalls; one read and one write port move one entry per cycle.
// Reset clears the entry count and sets key_mask to all ones; entries are not cleared.
// A stall on out holds the result and the traverse walk; in is stalled while an operation runs.
module sequential_list_engine_top #(
	parameter int DEPTH      = sle_pkg::DEPTH_DEF,
	parameter int ELEM_WIDTH = sle_pkg::ELEM_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [sle_pkg::MODE_W-1:0]   mode,
	input  logic [sle_pkg::POS_IN_W-1:0] position_in,
	input  logic [sle_pkg::DATA_W-1:0]   element_value,
	input  logic [sle_pkg::DATA_W-1:0]   search_key,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [sle_pkg::STATUS_W-1:0] status,
	output logic [sle_pkg::POS_W-1:0]    position_out,
	output logic [sle_pkg::DATA_W-1:0]   element_out,
	output logic [sle_pkg::COUNT_W-1:0]  count,
	output logic                         last,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [sle_pkg::DATA_W-1:0]   cfg_data
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [sle_pkg::DATA_W-1:0] key_mask_q;
	logic                       out_ready;
	logic                       push;
	sle_pkg::result_t           push_res;
	logic                       rd_en;
	logic [AW-1:0]              rd_addr;
	logic [ELEM_WIDTH-1:0]      rd_data;
	logic                       wr_en;
	logic [AW-1:0]              wr_addr;
	logic [ELEM_WIDTH-1:0]      wr_data;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_mask_q <= '1;
		end else if (cfg_valid && cfg_ready) begin
			key_mask_q <= cfg_data;
		end
	end

	sle_ctrl #(
		.DEPTH      (DEPTH),
		.ELEM_WIDTH (ELEM_WIDTH)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.mode          (mode),
		.position_in   (position_in),
		.element_value (element_value),
		.search_key    (search_key),
		.key_mask      (key_mask_q),
		.out_ready     (out_ready),
		.push          (push),
		.push_res      (push_res),
		.rd_en         (rd_en),
		.rd_addr       (rd_addr),
		.rd_data       (rd_data),
		.wr_en         (wr_en),
		.wr_addr       (wr_addr),
		.wr_data       (wr_data)
	);

	sle_mem #(
		.DEPTH      (DEPTH),
		.ELEM_WIDTH (ELEM_WIDTH)
	) u_mem (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	sle_out u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.push_res     (push_res),
		.out_ready    (out_ready),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.position_out (position_out),
		.element_out  (element_out),
		.count        (count),
		.last         (last)
	);

endmodule
